>>> rtl/ipv4rw_pkg.sv
// Shared types, constants and the one's-complement adder for the address rewrite unit.
package ipv4rw_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 65535;
    localparam int QUEUE_DEPTH_DEF      = 8;

    localparam logic [7:0] PROTO_TCP = 8'd6;

    localparam int ADDR_W  = 32;
    localparam int SUM_W   = 16;
    localparam int CFG_W   = 32;

    typedef enum logic [0:0] {
        CFG_MATCH   = 1'b0,
        CFG_REPLACE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_DST  = 2'd1,
        ACT_SRC  = 2'd2,
        ACT_BAD  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_HDR  = 2'd1,
        SEL_SEG  = 2'd2
    } t_sum_sel;

    typedef enum logic [0:0] {
        ST_ACCUM = 1'b0,
        ST_FIN   = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [SUM_W-1:0]  word;
        t_sum_sel          sel;
        logic              fin;
        logic              bad;
        logic              tcp;
        logic [SUM_W-1:0]  seglen;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } t_word_entry;

    function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
    endfunction

endpackage

>>> rtl/ipv4rw_byte_if.sv
// Input channel carrying one packet byte per word with a last flag.
interface ipv4rw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

>>> rtl/ipv4rw_result_if.sv
// Output channel carrying one rewrite result per packet.
interface ipv4rw_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] new_source;
    logic [31:0] new_destination;
    logic [15:0] header_checksum;
    logic [15:0] segment_checksum;

    modport source (output valid, output action, output new_source,
                    output new_destination, output header_checksum,
                    output segment_checksum, input ready);
    modport sink   (input valid, input action, input new_source,
                    input new_destination, input header_checksum,
                    input segment_checksum, output ready);
endinterface

>>> rtl/ipv4rw_front.sv
// Front end: takes packet bytes, pairs them into words and classifies each word.
module ipv4rw_front #(
    parameter int MAX_PACKET_BYTES = ipv4rw_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ipv4rw_byte_if.sink              i_in,
    input  logic                     i_full,
    output logic                     o_push,
    output ipv4rw_pkg::t_word_entry  o_entry
);
    import ipv4rw_pkg::*;

    localparam int CW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int XW = CW + 1;

    logic [CW-1:0]  r_cnt, n_cnt;
    logic [3:0]     r_ihl, n_ihl;
    logic [7:0]     r_proto, n_proto;
    logic [31:0]    r_src, n_src;
    logic [31:0]    r_dst, n_dst;
    logic [7:0]     r_pend, n_pend;

    logic           accept;
    logic           counted;
    logic           has_word;
    logic [15:0]    word;
    logic [XW-1:0]  start;
    logic [XW-1:0]  hb;
    logic [XW-1:0]  len;
    logic           tcp;
    logic           hdr_excl;
    t_sum_sel       sel;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign counted    = (r_cnt != CW'(MAX_PACKET_BYTES));

    always_comb begin
        n_cnt   = r_cnt;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_pend  = r_pend;
        if (counted) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == '0) begin
                n_ihl = i_in.data_byte[3:0];
            end
            if (r_cnt == CW'(9)) begin
                n_proto = i_in.data_byte;
            end
            if (r_cnt >= CW'(12) && r_cnt <= CW'(15)) begin
                n_src = {r_src[23:0], i_in.data_byte};
            end
            if (r_cnt >= CW'(16) && r_cnt <= CW'(19)) begin
                n_dst = {r_dst[23:0], i_in.data_byte};
            end
            if (!r_cnt[0]) begin
                n_pend = i_in.data_byte;
            end
        end
    end

    always_comb begin
        if (counted && r_cnt[0]) begin
            has_word = 1'b1;
            word     = {r_pend, i_in.data_byte};
        end else if (counted) begin
            has_word = i_in.last;
            word     = {i_in.data_byte, 8'h00};
        end else begin
            has_word = i_in.last && r_cnt[0];
            word     = {r_pend, 8'h00};
        end
    end

    assign start    = {1'b0, r_cnt[CW-1:1], 1'b0};
    assign hb       = XW'({n_ihl, 2'b00});
    assign len      = XW'(n_cnt);
    assign tcp      = (n_proto == PROTO_TCP);
    assign hdr_excl = (start == XW'(10)) || (start >= XW'(12) && start <= XW'(18));

    always_comb begin
        if (!has_word) begin
            sel = SEL_NONE;
        end else if (start < hb) begin
            sel = hdr_excl ? SEL_NONE : SEL_HDR;
        end else begin
            sel = (start == hb + XW'(16)) ? SEL_NONE : SEL_SEG;
        end
    end

    always_comb begin
        o_entry.word   = word;
        o_entry.sel    = sel;
        o_entry.fin    = i_in.last;
        o_entry.bad    = (len < XW'(20)) || (n_ihl < 4'd5) || (len < hb) ||
                         (tcp && (len < hb + XW'(20)));
        o_entry.tcp    = tcp;
        o_entry.seglen = 16'(len - hb);
        o_entry.src    = n_src;
        o_entry.dst    = n_dst;
    end

    assign o_push = accept && (has_word || i_in.last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_pend  <= '0;
        end else if (accept) begin
            if (i_in.last) begin
                r_cnt   <= '0;
                r_ihl   <= '0;
                r_proto <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_pend  <= '0;
            end else begin
                r_cnt   <= n_cnt;
                r_ihl   <= n_ihl;
                r_proto <= n_proto;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_pend  <= n_pend;
            end
        end
    end

endmodule

>>> rtl/ipv4rw_fifo.sv
// Short queue of classified words between the front and back ends.
module ipv4rw_fifo #(
    parameter int DEPTH = ipv4rw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  ipv4rw_pkg::t_word_entry  i_entry,
    input  logic                     i_pop,
    output logic                     o_full,
    output logic                     o_empty,
    output ipv4rw_pkg::t_word_entry  o_entry
);
    import ipv4rw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_word_entry    r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");
`endif

endmodule

>>> rtl/ipv4rw_back.sv
// Back end: running sums, rewrite decision, checksum finish and result register.
module ipv4rw_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  ipv4rw_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [31:0]              i_cfg_data,
    input  logic                     i_empty,
    input  ipv4rw_pkg::t_word_entry  i_entry,
    output logic                     o_pop,
    ipv4rw_result_if.source          o_out
);
    import ipv4rw_pkg::*;

    localparam logic [2:0] STEP_SRC_HI = 3'd0;
    localparam logic [2:0] STEP_SRC_LO = 3'd1;
    localparam logic [2:0] STEP_DST_HI = 3'd2;
    localparam logic [2:0] STEP_DST_LO = 3'd3;
    localparam logic [2:0] STEP_PROTO  = 3'd4;
    localparam logic [2:0] STEP_LAST   = 3'd5;

    logic [31:0]  r_match, r_replace;
    t_back_state  r_state, n_state;
    logic [2:0]   r_step, n_step;
    logic [15:0]  r_hsum, n_hsum;
    logic [15:0]  r_ssum, n_ssum;
    t_action      r_act, n_act;
    logic         r_tcp, n_tcp;
    logic [15:0]  r_seglen, n_seglen;
    logic [31:0]  r_src, n_src;
    logic [31:0]  r_dst, n_dst;

    logic         r_ov, n_ov;
    t_action      r_o_act, n_o_act;
    logic [31:0]  r_o_src, n_o_src;
    logic [31:0]  r_o_dst, n_o_dst;
    logic [15:0]  r_o_hck, n_o_hck;
    logic [15:0]  r_o_sck, n_o_sck;

    logic         can_load;
    logic [15:0]  h_op, s_op;

    assign can_load = !r_ov || o_out.ready;

    always_comb begin
        unique case (r_step)
            STEP_SRC_HI: begin h_op = r_src[31:16]; s_op = r_src[31:16]; end
            STEP_SRC_LO: begin h_op = r_src[15:0];  s_op = r_src[15:0];  end
            STEP_DST_HI: begin h_op = r_dst[31:16]; s_op = r_dst[31:16]; end
            STEP_DST_LO: begin h_op = r_dst[15:0];  s_op = r_dst[15:0];  end
            STEP_PROTO:  begin h_op = '0;           s_op = 16'(PROTO_TCP); end
            default:     begin h_op = '0;           s_op = r_seglen;     end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_hsum   = r_hsum;
        n_ssum   = r_ssum;
        n_act    = r_act;
        n_tcp    = r_tcp;
        n_seglen = r_seglen;
        n_src    = r_src;
        n_dst    = r_dst;
        n_ov     = r_ov && !o_out.ready;
        n_o_act  = r_o_act;
        n_o_src  = r_o_src;
        n_o_dst  = r_o_dst;
        n_o_hck  = r_o_hck;
        n_o_sck  = r_o_sck;
        o_pop    = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_entry.sel)
                        SEL_HDR:  n_hsum = oc_add(r_hsum, i_entry.word);
                        SEL_SEG:  n_ssum = oc_add(r_ssum, i_entry.word);
                        SEL_NONE: ;
                        default:  ;
                    endcase
                    if (i_entry.fin) begin
                        n_state  = ST_FIN;
                        n_step   = STEP_SRC_HI;
                        n_tcp    = i_entry.tcp;
                        n_seglen = i_entry.seglen;
                        n_src    = i_entry.src;
                        n_dst    = i_entry.dst;
                        n_act    = ACT_NONE;
                        if (i_entry.bad) begin
                            n_act = ACT_BAD;
                        end else if (i_entry.tcp && i_entry.dst == r_match) begin
                            n_dst = r_replace;
                            n_act = ACT_DST;
                        end else if (i_entry.tcp && i_entry.src == r_replace) begin
                            n_src = r_match;
                            n_act = ACT_SRC;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (r_step != STEP_LAST) begin
                    n_hsum = oc_add(r_hsum, h_op);
                    n_ssum = oc_add(r_ssum, s_op);
                    n_step = r_step + 1'b1;
                end else if (can_load) begin
                    n_ov    = 1'b1;
                    n_o_act = r_act;
                    if (r_act == ACT_BAD) begin
                        n_o_src = '0;
                        n_o_dst = '0;
                        n_o_hck = '0;
                        n_o_sck = '0;
                    end else begin
                        n_o_src = r_src;
                        n_o_dst = r_dst;
                        n_o_hck = ~r_hsum;
                        n_o_sck = r_tcp ? ~oc_add(r_ssum, s_op) : '0;
                    end
                    n_hsum  = '0;
                    n_ssum  = '0;
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match   <= '0;
            r_replace <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH:   r_match   <= i_cfg_data;
                CFG_REPLACE: r_replace <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
            r_step  <= '0;
            r_hsum  <= '0;
            r_ssum  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_hsum  <= n_hsum;
            r_ssum  <= n_ssum;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_tcp    <= n_tcp;
        r_seglen <= n_seglen;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_o_act  <= n_o_act;
        r_o_src  <= n_o_src;
        r_o_dst  <= n_o_dst;
        r_o_hck  <= n_o_hck;
        r_o_sck  <= n_o_sck;
    end

    assign o_out.valid            = r_ov;
    assign o_out.action           = r_o_act;
    assign o_out.new_source       = r_o_src;
    assign o_out.new_destination  = r_o_dst;
    assign o_out.header_checksum  = r_o_hck;
    assign o_out.segment_checksum = r_o_sck;

`ifndef SYNTHESIS
    a_no_pop_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> !o_pop)
        else $error("word taken while finishing a packet");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST)
        else $error("finish step out of range");
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_act == ACT_BAD) |->
            (r_o_src == '0 && r_o_dst == '0 && r_o_hck == '0 && r_o_sck == '0))
        else $error("malformed result carries nonzero fields");
    a_sums_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && n_state == ST_ACCUM) |=> (r_hsum == '0 && r_ssum == '0))
        else $error("sums not cleared after a packet");
`endif

endmodule

>>> rtl/ipv4_tcp_addr_rewrite_checksum_unit.sv
// Top level of the IPv4 TCP address rewrite and checksum recompute unit.
// Packet bytes are taken one per cycle while the word queue has room. Each
// packet end holds the back end for address and pseudo-header additions, so
// with the default eight-entry queue packets of twelve bytes or more sustain
// one byte per cycle while results are taken; the result of a packet is
// registered after those additions and waits in an output register, where it
// blocks the finish of the next packet until it is taken.
module ipv4_tcp_addr_rewrite_checksum_unit #(
    parameter int MAX_PACKET_BYTES = ipv4rw_pkg::MAX_PACKET_BYTES_DEF,
    parameter int QUEUE_DEPTH      = ipv4rw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  ipv4rw_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    ipv4rw_byte_if.sink           i_in,
    ipv4rw_result_if.source       o_out
);
    import ipv4rw_pkg::*;

    logic         push, pop, full, empty;
    t_word_entry  push_entry, head_entry;

    ipv4rw_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    ipv4rw_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (head_entry)
    );

    ipv4rw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (empty),
        .i_entry    (head_entry),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the IPv4 TCP address rewrite and checksum recompute unit.
module tb_top;
    import ipv4rw_pkg::*;

    localparam int PKT_MAX     = MAX_PACKET_BYTES_DEF;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE_CYC  = 24;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_BYTES = 180;

    typedef struct packed {
        t_action     action;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] hck;
        logic [15:0] sck;
    } t_rw_result;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_pkt_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [31:0] cfg_data;

    ipv4rw_byte_if   in_if ();
    ipv4rw_result_if out_if ();

    ipv4_tcp_addr_rewrite_checksum_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if.sink),
        .o_out      (out_if.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the per-packet state.
    logic [31:0] cur_match;
    logic [31:0] cur_replace;
    int          byte_cnt;
    logic [3:0]  hdr_words;
    logic [7:0]  proto;
    logic [31:0] src_acc;
    logic [31:0] dst_acc;
    logic [15:0] hdr_sum;
    logic [15:0] seg_sum;
    logic [7:0]  hi_byte;

    t_pkt_byte  byte_feed_q[$];
    t_rw_result rewrite_due_q[$];

    bit rst_done;
    bit in_fire;
    bit out_fire;
    bit no_idle;
    bit hold_arm;
    bit hold_taken;
    int hold_cnt;
    int src_gap;
    int sink_gap;
    int bytes_queued;
    int bytes_taken;
    int mismatch_cnt;
    int idle_cycles;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s > 65535) s = s - 65535;
        return s[15:0];
    endfunction

    function automatic logic [15:0] fold_addr(input logic [15:0] acc, input logic [31:0] a);
        return fold_add(fold_add(acc, a[31:16]), a[15:0]);
    endfunction

    task automatic route_word(input int start, input logic [15:0] w);
        int hb;
        hb = int'(hdr_words) * 4;
        if (start < hb) begin
            if (!(start == 10 || (start >= 12 && start <= 18))) hdr_sum = fold_add(hdr_sum, w);
        end else if (start != hb + 16) begin
            seg_sum = fold_add(seg_sum, w);
        end
    endtask

    task automatic nat_predict_byte(input logic [7:0] b, input logic fin,
                                    output bit got, output t_rw_result r);
        int          pos;
        int          len;
        int          hb;
        logic        tcp;
        logic [31:0] s;
        logic [31:0] d;
        logic [15:0] hs;
        logic [15:0] ss;
        got = 1'b0;
        r   = '0;
        pos = byte_cnt;
        if (pos < PKT_MAX) begin
            if (pos == 0) hdr_words = b[3:0];
            if (pos == 9) proto = b;
            if (pos >= 12 && pos <= 15) src_acc = {src_acc[23:0], b};
            if (pos >= 16 && pos <= 19) dst_acc = {dst_acc[23:0], b};
            if (pos % 2 == 0) hi_byte = b;
            else route_word(pos - 1, {hi_byte, b});
            byte_cnt = pos + 1;
        end
        if (fin) begin
            got = 1'b1;
            len = byte_cnt;
            hb  = int'(hdr_words) * 4;
            tcp = (proto == PROTO_TCP);
            if (len % 2 == 1) route_word(len - 1, {hi_byte, 8'h00});
            if (len < 20 || hdr_words < 4'd5 || len < hb || (tcp && len < hb + 20)) begin
                r.action = ACT_BAD;
            end else begin
                s = src_acc;
                d = dst_acc;
                r.action = ACT_NONE;
                if (tcp && d == cur_match) begin
                    d = cur_replace;
                    r.action = ACT_DST;
                end else if (tcp && s == cur_replace) begin
                    s = cur_match;
                    r.action = ACT_SRC;
                end
                hs = fold_addr(fold_addr(hdr_sum, s), d);
                r.hck = ~hs;
                if (tcp) begin
                    ss = fold_addr(fold_addr(seg_sum, s), d);
                    ss = fold_add(ss, {8'h00, proto});
                    ss = fold_add(ss, 16'(len - hb));
                    r.sck = ~ss;
                end
                r.src = s;
                r.dst = d;
            end
            byte_cnt  = 0;
            hdr_words = '0;
            proto     = '0;
            src_acc   = '0;
            dst_acc   = '0;
            hdr_sum   = '0;
            seg_sum   = '0;
            hi_byte   = '0;
        end
    endtask

    function automatic int next_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: one word per handshake, next word offered at the falling edge.
    always @(negedge i_clk) begin
        if (!in_if.valid || in_fire) begin
            if (src_gap > 0) begin
                src_gap--;
                in_if.valid <= 1'b0;
            end else if (rst_done && byte_feed_q.size() > 0) begin
                t_pkt_byte it;
                it = byte_feed_q.pop_front();
                in_if.valid     <= 1'b1;
                in_if.data_byte <= it.data;
                in_if.last      <= it.last;
                src_gap = next_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver with random stalls and one long hold-off.
    always @(negedge i_clk) begin
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            hold_cnt   = LONG_HOLD;
        end
        if (out_fire) sink_gap = next_gap();
        if (!rst_done) begin
            out_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            out_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor, checker and watchdog.
    always @(posedge i_clk) begin
        bit         got;
        t_rw_result r;
        t_rw_result e;
        in_fire  = rst_done && in_if.valid && in_if.ready;
        out_fire = rst_done && out_if.valid && out_if.ready;
        if (in_fire) begin
            bytes_taken++;
            nat_predict_byte(in_if.data_byte, in_if.last, got, r);
            if (got) rewrite_due_q.push_back(r);
        end
        if (out_fire) begin
            if (rewrite_due_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word: action=%0d src=%h dst=%h hck=%h sck=%h",
                             out_if.action, out_if.new_source, out_if.new_destination,
                             out_if.header_checksum, out_if.segment_checksum);
            end else begin
                e = rewrite_due_q.pop_front();
                if (out_if.action !== e.action || out_if.new_source !== e.src ||
                    out_if.new_destination !== e.dst || out_if.header_checksum !== e.hck ||
                    out_if.segment_checksum !== e.sck) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp %0d %h %h %h %h / got %0d %h %h %h %h",
                                 e.action, e.src, e.dst, e.hck, e.sck,
                                 out_if.action, out_if.new_source, out_if.new_destination,
                                 out_if.header_checksum, out_if.segment_checksum);
                end
            end
        end
        if (rst_done) begin
            if (in_fire || out_fire) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_MATCH) cur_match = val;
        else cur_replace = val;
    endtask

    task automatic set_addrs(input logic [31:0] m, input logic [31:0] r);
        write_reg(CFG_MATCH, m);
        write_reg(CFG_REPLACE, r);
    endtask

    task automatic queue_packet(input logic [7:0] ver_ihl, input logic [7:0] prot,
                                input logic [31:0] s, input logic [31:0] d,
                                input int total, input int fill);
        t_pkt_byte  it;
        logic [7:0] v;
        for (int i = 0; i < total; i++) begin
            v = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (i == 0) v = ver_ihl;
            else if (i == 9) v = prot;
            else if (i >= 12 && i <= 15) v = s[8*(15-i) +: 8];
            else if (i >= 16 && i <= 19) v = d[8*(19-i) +: 8];
            it.data = v;
            it.last = (i == total - 1);
            byte_feed_q.push_back(it);
        end
        bytes_queued += total;
    endtask

    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return cur_match;
        if (r < 55) return cur_replace;
        return $urandom;
    endfunction

    task automatic random_packet();
        int         r;
        int         ihl;
        int         len;
        logic [7:0] prot;
        logic [3:0] ver;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            ihl  = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : 5;
            ver  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h4;
            prot = ($urandom_range(0, 3) != 0) ? PROTO_TCP : 8'($urandom);
            if (prot == PROTO_TCP) begin
                if ($urandom_range(0, 9) == 0) len = $urandom_range(1, ihl * 4 + 19);
                else len = ihl * 4 + 20 + $urandom_range(0, 24);
            end else begin
                len = ihl * 4 + $urandom_range(0, 30);
            end
            queue_packet({ver, 4'(ihl)}, prot, pick_addr(), pick_addr(), len, -1);
        end else if (r < 90) begin
            queue_packet(8'($urandom), 8'($urandom), $urandom, $urandom,
                         $urandom_range(1, 45), -1);
        end else begin
            queue_packet({4'h4, 4'($urandom)}, PROTO_TCP, pick_addr(), pick_addr(),
                         $urandom_range(1, 80), -1);
        end
    endtask

    task automatic random_phase(input int nbytes);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < nbytes) random_packet();
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued || rewrite_due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] m;
        logic [31:0] r;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_MATCH;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = '0;
        in_if.last      = 1'b0;
        out_if.ready    = 1'b0;
        cur_match       = '0;
        cur_replace     = '0;
        byte_cnt        = 0;
        hdr_words       = '0;
        proto           = '0;
        src_acc         = '0;
        dst_acc         = '0;
        hdr_sum         = '0;
        seg_sum         = '0;
        hi_byte         = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        m = 32'h0a000001;
        r = 32'hc0a80001;
        set_addrs(m, r);
        queue_packet(8'h45, PROTO_TCP, 32'h01020304, m, 40, -1);
        queue_packet(8'h45, PROTO_TCP, r, 32'h05060708, 41, -1);
        queue_packet(8'h45, PROTO_TCP, r, m, 44, -1);
        queue_packet(8'h45, 8'd17, r, m, 33, -1);
        queue_packet(8'h45, PROTO_TCP, 32'h01020304, 32'h05060708, 39, -1);
        queue_packet(8'h44, PROTO_TCP, r, m, 40, -1);
        queue_packet(8'h4f, PROTO_TCP, r, 32'h11223344, 80, -1);
        queue_packet(8'h4f, 8'd17, r, m, 50, -1);
        queue_packet(8'h45, PROTO_TCP, m, m, 19, -1);
        queue_packet(8'hff, 8'h00, 32'h0, 32'h0, 1, -1);
        queue_packet(8'h00, 8'h00, 32'h0, 32'h0, 40, 0);
        queue_packet(8'hff, 8'hff, 32'hffffffff, 32'hffffffff, 61, 255);
        queue_packet(8'h4f, PROTO_TCP, 32'hffffffff, 32'hffffffff, 81, 255);
        drain();

        set_addrs(32'hffffffff, 32'h00000000);
        random_phase(PHASE_BYTES);
        drain();

        // Receiver holds off while the sender keeps the input full.
        set_addrs(32'h00000000, 32'hffffffff);
        no_idle = 1'b1;
        random_phase(PHASE_BYTES);
        hold_arm = 1'b1;
        drain();
        no_idle = 1'b0;

        set_addrs(32'hffffffff, 32'hffffffff);
        random_phase(PHASE_BYTES);
        drain();

        set_addrs(32'h00000000, 32'h00000000);
        random_phase(PHASE_BYTES);
        drain();

        set_addrs($urandom, $urandom);
        random_phase(PHASE_BYTES);
        drain();

        set_addrs($urandom, $urandom);
        no_idle = 1'b1;
        random_phase(PHASE_BYTES);
        drain();
        no_idle = 1'b0;

        set_addrs($urandom, $urandom);
        random_phase(PHASE_BYTES / 2);
        drain();

        if (mismatch_cnt == 0 && rewrite_due_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
